@@ rtl/ohlc_pkg.sv @@
// Shared types and constants of the OHLC candle aggregator.
`default_nettype none

package ohlc_pkg;

    localparam int INST_W   = 4;
    localparam int PRICE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int RATIO_W  = 14;
    localparam int PERIOD_W = 17;
    localparam int DIV_W    = 32;
    localparam int PROD_W   = PRICE_W + RATIO_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(900);
    localparam logic [RATIO_W-1:0]  RATIO_SCALE  = RATIO_W'(10000);

    // Index of the last two-bit step for each kind of division.
    localparam logic [3:0] PAIRS_RATIO = 4'd6;
    localparam logic [3:0] PAIRS_TIME  = 4'd15;

    typedef struct packed {
        logic [INST_W-1:0]  instrument;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  time_seconds;
    } t_tick;

    typedef struct packed {
        logic [INST_W-1:0]  which_instrument;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic               is_green;
        logic [RATIO_W-1:0] body_ratio;
        logic [RATIO_W-1:0] wick_ratio;
        logic [RATIO_W-1:0] range_ratio;
        logic [PRICE_W-1:0] day_high;
        logic [PRICE_W-1:0] day_low;
    } t_candle;

    // One instrument's stored state.
    typedef struct packed {
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [TIME_W-1:0]  end_time;
        logic [PRICE_W-1:0] day_hi;
        logic [PRICE_W-1:0] day_lo;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] sh_init;
        logic [DIV_W-1:0] divisor;
        logic [3:0]       last_pair;
    } t_div_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/ohlc_div.sv @@
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none

module ohlc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ohlc_pkg::t_div_cmd i_cmd,
    output ohlc_pkg::t_div_rsp o_rsp
);
    import ohlc_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_sh;
    logic [DIV_W-1:0] r_div;
    logic [3:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   rem_a;
    logic [DIV_W:0]   rem_b;
    logic             ge_a;
    logic             ge_b;
    logic [DIV_W-1:0] rem1;
    logic [DIV_W-1:0] rem2;
    logic [DIV_W-1:0] sh1;
    logic [DIV_W-1:0] sh2;

    // The partial remainder stays below the divisor, so each shifted value fits in 33 bits.
    always_comb begin
        rem_a = {r_rem, r_sh[DIV_W-1]};
        ge_a  = rem_a >= {1'b0, r_div};
        rem1  = ge_a ? DIV_W'(rem_a - {1'b0, r_div}) : rem_a[DIV_W-1:0];
        sh1   = {r_sh[DIV_W-2:0], ge_a};
        rem_b = {rem1, sh1[DIV_W-1]};
        ge_b  = rem_b >= {1'b0, r_div};
        rem2  = ge_b ? DIV_W'(rem_b - {1'b0, r_div}) : rem_b[DIV_W-1:0];
        sh2   = {sh1[DIV_W-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.last_pair;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.rem_init;
            r_sh  <= i_cmd.sh_init;
            r_div <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_sh  <= sh2;
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quo: r_sh, rem: r_rem};

endmodule

`default_nettype wire

@@ rtl/ohlc_mem.sv @@
// Per-instrument state memory with a seen flag for each entry.
`default_nettype none

module ohlc_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  ohlc_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output ohlc_pkg::t_entry o_rd_data,
    output logic             o_rd_seen
);
    import ohlc_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_seen;
    t_entry           r_rd_data;
    logic             r_rd_seen;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // The seen flags mark entries that hold data; reset clears them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_seen[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_seen <= r_seen[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_seen = r_rd_seen;

endmodule

`default_nettype wire

@@ rtl/ohlc_candle_aggregator_core.sv @@
// Top level of the OHLC candle aggregator: sequencer, config register and output stage.
//
//  Channel   Dir  Signals                                  Beat taken when
//  tick      in   i_tick_valid, o_tick_ready, i_tick       i_tick_valid && o_tick_ready
//  candle    out  o_candle_valid, i_candle_ready, o_candle o_candle_valid && i_candle_ready
//  config    in   i_cfg_wr_en, i_cfg_wr_data               i_cfg_wr_en
//
// A tick beat for an instrument out of range is taken and dropped; a tick inside the open
// candle updates the stored entry; the first tick of an instrument and a tick that
// closes a candle run the period alignment on the shared two-bit-per-cycle divider, and a
// closing tick first runs the body and range ratios on it, skipping a ratio whose divisor
// is zero. Each division is started from a load state ahead of its stepping.
// The reset is synchronous and active low; it clears the seen flags, so no clearing pass
// is needed, and loads a period of 900 seconds. A finished candle waits in the output
// register while the next tick beat is taken; the block stalls only if a second candle
// is ready before the first has been taken.
`default_nettype none

module ohlc_candle_aggregator_core #(
    parameter int NUM_INSTRUMENTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tick_valid,
    output logic                              o_tick_ready,
    input  ohlc_pkg::t_tick                   i_tick,
    output logic                              o_candle_valid,
    input  logic                              i_candle_ready,
    output ohlc_pkg::t_candle                 o_candle,
    input  logic                              i_cfg_wr_en,
    input  logic [ohlc_pkg::PERIOD_W-1:0]     i_cfg_wr_data
);
    import ohlc_pkg::*;

    // Only indexes that the instrument field can carry need storage.
    localparam int DEPTH = (NUM_INSTRUMENTS < (2 ** INST_W)) ? NUM_INSTRUMENTS : (2 ** INST_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MUL_B,
        S_DIV_B,
        S_WAIT_B,
        S_MUL_R,
        S_DIV_R,
        S_WAIT_R,
        S_PER,
        S_WAIT_P,
        S_EMIT
    } t_state;

    t_state              r_state,  n_state;
    logic [PERIOD_W-1:0] r_period, n_period;
    t_tick               r_tick,   n_tick;
    logic                r_closing, n_closing;
    logic [PRICE_W-1:0]  r_o, n_o;
    logic [PRICE_W-1:0]  r_h, n_h;
    logic [PRICE_W-1:0]  r_l, n_l;
    logic [PRICE_W-1:0]  r_dh, n_dh;
    logic [PRICE_W-1:0]  r_dl, n_dl;
    logic [PRICE_W-1:0]  r_range, n_range;
    logic [PRICE_W-1:0]  r_diff, n_diff;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [RATIO_W-1:0]  r_body, n_body;
    logic [RATIO_W-1:0]  r_rr, n_rr;
    logic                r_out_valid, n_out_valid;
    t_candle             r_out, n_out;

    logic                accept;
    logic                in_range;
    logic                mem_we;
    t_entry              mem_wdata;
    t_entry              rd_entry;
    logic                rd_seen;
    t_div_cmd            div_cmd;
    t_div_rsp            div_rsp;

    logic [PRICE_W-1:0]  upd_ch;
    logic [PRICE_W-1:0]  upd_cl;
    logic [PRICE_W-1:0]  upd_dh;
    logic [PRICE_W-1:0]  upd_dl;
    logic                upd_close;
    logic [DIV_W-1:0]    period_eff;
    logic [TIME_W-1:0]   end_base;
    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   end_time;
    logic [RATIO_W-1:0]  quo_clamped;

    assign o_tick_ready   = (r_state == S_IDLE);
    assign accept         = i_tick_valid && o_tick_ready;
    assign in_range       = int'(i_tick.instrument) < NUM_INSTRUMENTS;
    assign o_candle_valid = r_out_valid;
    assign o_candle       = r_out;

    ohlc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_tick.instrument[AW-1:0]),
        .i_wr_data (mem_wdata),
        .i_rd_en   (accept && in_range),
        .i_rd_addr (i_tick.instrument[AW-1:0]),
        .o_rd_data (rd_entry),
        .o_rd_seen (rd_seen)
    );

    ohlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    // Fold the tick's price into the stored candle and day extremes. The closing
    // price counts toward the candle's high and low as well.
    always_comb begin
        upd_ch    = (r_tick.price > rd_entry.high_p) ? r_tick.price : rd_entry.high_p;
        upd_cl    = (r_tick.price < rd_entry.low_p)  ? r_tick.price : rd_entry.low_p;
        upd_dh    = (r_tick.price > rd_entry.day_hi) ? r_tick.price : rd_entry.day_hi;
        upd_dl    = (r_tick.price < rd_entry.day_lo) ? r_tick.price : rd_entry.day_lo;
        upd_close = r_tick.time_seconds >= rd_entry.end_time;
    end

    // The next candle ends at the next multiple of the period after the tick time,
    // worked out as t - (t mod P) + P and saturated at the top of the time range.
    // A period of zero acts as one second.
    always_comb begin
        period_eff = (r_period == '0) ? DIV_W'(1) : DIV_W'(r_period);
        end_base   = r_tick.time_seconds - div_rsp.rem;
        end_sum    = {1'b0, end_base} + {1'b0, period_eff};
        end_time   = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
    end

    // Ratio quotients never exceed the scale for coherent state; clamp anyway.
    always_comb begin
        quo_clamped = (div_rsp.quo[RATIO_W-1:0] > RATIO_SCALE) ? RATIO_SCALE
                                                               : div_rsp.quo[RATIO_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_tick      = r_tick;
        n_closing   = r_closing;
        n_o         = r_o;
        n_h         = r_h;
        n_l         = r_l;
        n_dh        = r_dh;
        n_dl        = r_dl;
        n_range     = r_range;
        n_diff      = r_diff;
        n_prod      = r_prod;
        n_body      = r_body;
        n_rr        = r_rr;
        n_out_valid = r_out_valid && !i_candle_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = rd_entry;
        div_cmd     = '0;

        if (i_cfg_wr_en) begin
            n_period = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tick = i_tick;
                    if (in_range) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (!rd_seen) begin
                    // First tick of this instrument: open a candle, emit nothing.
                    n_dh      = r_tick.price;
                    n_dl      = r_tick.price;
                    n_closing = 1'b0;
                    n_state   = S_PER;
                end else if (!upd_close) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{open_p:   rd_entry.open_p,
                                  high_p:   upd_ch,
                                  low_p:    upd_cl,
                                  end_time: rd_entry.end_time,
                                  day_hi:   upd_dh,
                                  day_lo:   upd_dl};
                    n_state   = S_IDLE;
                end else begin
                    n_o       = rd_entry.open_p;
                    n_h       = upd_ch;
                    n_l       = upd_cl;
                    n_dh      = upd_dh;
                    n_dl      = upd_dl;
                    n_range   = upd_ch - upd_cl;
                    n_diff    = (rd_entry.open_p > r_tick.price) ? rd_entry.open_p - r_tick.price
                                                                 : r_tick.price - rd_entry.open_p;
                    n_closing = 1'b1;
                    n_state   = S_MUL_B;
                end
            end
            S_MUL_B: begin
                n_prod  = PROD_W'(r_diff) * PROD_W'(RATIO_SCALE);
                n_state = S_DIV_B;
            end
            S_DIV_B: begin
                if (r_range == '0) begin
                    n_body  = '0;
                    n_state = S_MUL_R;
                end else begin
                    div_cmd = '{start:     1'b1,
                                rem_init:  r_prod[PROD_W-1:RATIO_W],
                                sh_init:   {r_prod[RATIO_W-1:0], {(DIV_W-RATIO_W){1'b0}}},
                                divisor:   r_range,
                                last_pair: PAIRS_RATIO};
                    n_state = S_WAIT_B;
                end
            end
            S_WAIT_B: begin
                if (div_rsp.done) begin
                    n_body  = quo_clamped;
                    n_state = S_MUL_R;
                end
            end
            S_MUL_R: begin
                n_prod  = PROD_W'(r_range) * PROD_W'(RATIO_SCALE);
                n_state = S_DIV_R;
            end
            S_DIV_R: begin
                if (r_h == '0) begin
                    n_rr    = '0;
                    n_state = S_PER;
                end else begin
                    div_cmd = '{start:     1'b1,
                                rem_init:  r_prod[PROD_W-1:RATIO_W],
                                sh_init:   {r_prod[RATIO_W-1:0], {(DIV_W-RATIO_W){1'b0}}},
                                divisor:   r_h,
                                last_pair: PAIRS_RATIO};
                    n_state = S_WAIT_R;
                end
            end
            S_WAIT_R: begin
                if (div_rsp.done) begin
                    n_rr    = quo_clamped;
                    n_state = S_PER;
                end
            end
            S_PER: begin
                div_cmd = '{start:     1'b1,
                            rem_init:  '0,
                            sh_init:   DIV_W'(r_tick.time_seconds),
                            divisor:   period_eff,
                            last_pair: PAIRS_TIME};
                n_state = S_WAIT_P;
            end
            S_WAIT_P: begin
                if (div_rsp.done) begin
                    // Open the new candle at the tick's price.
                    mem_we    = 1'b1;
                    mem_wdata = '{open_p:   r_tick.price,
                                  high_p:   r_tick.price,
                                  low_p:    r_tick.price,
                                  end_time: end_time,
                                  day_hi:   r_dh,
                                  day_lo:   r_dl};
                    n_state   = r_closing ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_candle_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{which_instrument: r_tick.instrument,
                                    open_price:       r_o,
                                    high_price:       r_h,
                                    low_price:        r_l,
                                    close_price:      r_tick.price,
                                    is_green:         r_o < r_tick.price,
                                    body_ratio:       r_body,
                                    wick_ratio:       RATIO_SCALE - r_body,
                                    range_ratio:      r_rr,
                                    day_high:         r_dh,
                                    day_low:          r_dl};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_out_valid <= n_out_valid;
            r_tick      <= n_tick;
            r_closing   <= n_closing;
            r_o         <= n_o;
            r_h         <= n_h;
            r_l         <= n_l;
            r_dh        <= n_dh;
            r_dl        <= n_dl;
            r_range     <= n_range;
            r_diff      <= n_diff;
            r_prod      <= n_prod;
            r_body      <= n_body;
            r_rr        <= n_rr;
            r_out       <= n_out;
        end
    end

    // The divider only reports a result to a state that is waiting for one.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_WAIT_B || r_state == S_WAIT_R || r_state == S_WAIT_P))
        else $error("divider result arrived outside a wait state");

    // A new division never starts on top of one in progress.
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_cmd.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Extremes of an emitted candle nest inside the day extremes.
    a_candle_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_candle_valid |-> (o_candle.low_price <= o_candle.high_price &&
                            o_candle.day_low <= o_candle.low_price &&
                            o_candle.high_price <= o_candle.day_high))
        else $error("candle extremes out of order");

    // Body and wick split the full scale between them.
    a_ratio_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_candle_valid |-> (({1'b0, o_candle.body_ratio} + {1'b0, o_candle.wick_ratio})
                            == (RATIO_W + 1)'(RATIO_SCALE)))
        else $error("body and wick ratios do not sum to the scale");

endmodule

`default_nettype wire
